// ----- rtl/core/lidar_beam_to_pixel_core_defines.svh -----
// Assertion macros shared by the lidar beam to pixel core.
`ifndef LIDAR_BEAM_TO_PIXEL_CORE_DEFINES_SVH
`define LIDAR_BEAM_TO_PIXEL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbp assertion failed");
`define LBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbp assertion failed");
`else
`define LBP_ASSERT_IMP(lbl, ante, cons)
`define LBP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/lbp_pkg.sv -----
// Types and constants shared by the lidar beam to pixel core.
`default_nettype none
package lbp_pkg;

  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned Q_DEPTH = 4;
  localparam logic signed [33:0] CORDIC_ONE_K = 34'sd652032874;

  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    REG_ANGLE_START,
    REG_ANGLE_STEP,
    REG_RETRO,
    REG_SCALE,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_MOUNT_X,
    REG_MOUNT_Y
  } cfg_reg_e;

  typedef struct packed {
    logic [23:0]        angle_start;
    logic [23:0]        angle_step;
    logic [23:0]        retro_intensity;
    logic [15:0]        scale;
    logic [11:0]        center_x;
    logic [11:0]        center_y;
    logic signed [15:0] mount_x;
    logic signed [15:0] mount_y;
  } cfg_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic [15:0] raw_intensity;
    logic [23:0] angle;
  } beam_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/lbp_front.sv -----
// Front end: takes beams, reduces the index and forms the beam angle.
`default_nettype none
module lbp_front
  import lbp_pkg::*;
#(
  parameter int unsigned SCAN_STEPS = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] range_mm_i,
  input  logic [15:0] raw_intensity_i,
  input  logic [10:0] beam_index_i,
  input  logic [23:0] angle_start_i,
  input  logic [23:0] angle_step_i,
  input  logic        q_full_i,
  output logic        push_o,
  output beam_t       push_data_o
);

  localparam int unsigned RECIP = ((1 << 24) + SCAN_STEPS - 1) / SCAN_STEPS;
  localparam logic [24:0] RECIP_V = 25'(RECIP);
  localparam logic [12:0] STEPS_V = 13'(SCAN_STEPS);

  logic        adv;
  logic        v1_q, v2_q;
  logic [15:0] r1_q, raw1_q, r2_q, raw2_q;
  logic [10:0] idx1_q, qe1_q, rem2_q;
  logic [35:0] qprod;
  logic [23:0] qs;
  logic [10:0] rem;
  logic [34:0] angp;

  assign adv        = !(v2_q && q_full_i);
  assign in_stall_o = !adv;
  assign push_o     = v2_q && !q_full_i;

  assign qprod = 36'(beam_index_i) * 36'(RECIP_V);
  assign qs    = 24'(qe1_q) * 24'(STEPS_V);
  assign rem   = idx1_q - qs[10:0];
  assign angp  = 35'(rem2_q) * 35'(angle_step_i);

  assign push_data_o.range_mm      = r2_q;
  assign push_data_o.raw_intensity = raw2_q;
  assign push_data_o.angle         = angle_start_i + angp[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q   <= range_mm_i;
      raw1_q <= raw_intensity_i;
      idx1_q <= beam_index_i;
      qe1_q  <= qprod[34:24];
      r2_q   <= r1_q;
      raw2_q <= raw1_q;
      rem2_q <= rem;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lbp_fifo.sv -----
// Short queue of beams between the front end and the back end.
`default_nettype none
module lbp_fifo
  import lbp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  beam_t   data_i,
  input  logic    pop_i,
  output beam_t   data_o,
  output q_stat_t stat_o
);

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  beam_t          mem_q [Q_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CW'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lbp_back.sv -----
// Back end: square root, CORDIC, projection, division and result register.
`default_nettype none
module lbp_back
  import lbp_pkg::*;
#(
  parameter int unsigned CORDIC_ITERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               head_valid_i,
  input  beam_t              head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         norm_intensity_o,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o,
  output logic [15:0]        range_out_o
);

  localparam int unsigned NI = (CORDIC_ITERS > 16) ? CORDIC_ITERS : 16;

  function automatic logic signed [17:0] round_off(input logic signed [15:0] m,
                                                   input logic [15:0] s);
    logic [16:0] mag;
    logic [33:0] prod;
    mag  = m[15] ? (17'd0 - {m[15], m}) : {1'b0, m};
    prod = 34'(mag) * 34'(s) + 34'(32768);
    return m[15] ? -$signed({1'b0, prod[32:16]}) : $signed({1'b0, prod[32:16]});
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic adv;
  assign adv   = !(out_valid_o && out_stall_i);
  assign pop_o = adv && head_valid_i;

  // Loop section: each stage does one square-root step where DO_SQ is set and one rotation where DO_ROT is set.
  logic               vl_q  [NI+1];
  logic [15:0]        r_q   [NI+1];
  logic [15:0]        raw_q [NI+1];
  logic [31:0]        rs_q  [NI+1];
  logic signed [17:0] ox_q  [NI+1];
  logic signed [17:0] oy_q  [NI+1];
  logic signed [33:0] x_q   [NI+1];
  logic signed [33:0] y_q   [NI+1];
  logic signed [33:0] t_q   [NI+1];
  logic               ng_q  [NI+1];
  logic [31:0]        sv_q  [NI+1];
  logic [31:0]        sr_q  [NI+1];

  logic [31:0]        tw;
  logic signed [33:0] t_in, t_red;
  logic               neg_in;

  always_comb begin
    tw     = {head_i.angle, 8'h00};
    t_in   = {{2{tw[31]}}, tw};
    t_red  = t_in;
    neg_in = 1'b0;
    if (t_in > 34'sd1073741824) begin
      t_red  = t_in - 34'sd2147483648;
      neg_in = 1'b1;
    end else if (t_in < -34'sd1073741824) begin
      t_red  = t_in + 34'sd2147483648;
      neg_in = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q[0] <= 1'b0;
    end else if (adv) begin
      vl_q[0] <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[0]   <= head_i.range_mm;
      raw_q[0] <= head_i.raw_intensity;
      rs_q[0]  <= 32'(head_i.range_mm) * 32'(cfg_i.scale);
      ox_q[0]  <= round_off(cfg_i.mount_x, cfg_i.scale);
      oy_q[0]  <= round_off(cfg_i.mount_y, cfg_i.scale);
      x_q[0]   <= CORDIC_ONE_K;
      y_q[0]   <= '0;
      t_q[0]   <= t_red;
      ng_q[0]  <= neg_in;
      sv_q[0]  <= {head_i.range_mm, 16'h0000};
      sr_q[0]  <= '0;
    end
  end

  for (genvar j = 0; j < NI; j++) begin : g_loop
    localparam bit          DO_ROT = (j < CORDIC_ITERS);
    localparam bit          DO_SQ  = (j < 16);
    localparam logic [31:0] SQ_BIT = DO_SQ ? (32'h1 << (30 - 2 * (j % 16))) : 32'h0;
    localparam logic signed [33:0] ATN =
      $signed({2'b00, ATAN_TURNS[j % ATAN_LEN]});

    logic signed [33:0] xn, yn, tn;
    logic [31:0]        svn, srn, sum;

    always_comb begin
      xn  = x_q[j];
      yn  = y_q[j];
      tn  = t_q[j];
      svn = sv_q[j];
      srn = sr_q[j];
      sum = sr_q[j] + SQ_BIT;
      if (DO_ROT) begin
        if (t_q[j] >= 0) begin
          xn = x_q[j] - (y_q[j] >>> j);
          yn = y_q[j] + (x_q[j] >>> j);
          tn = t_q[j] - ATN;
        end else begin
          xn = x_q[j] + (y_q[j] >>> j);
          yn = y_q[j] - (x_q[j] >>> j);
          tn = t_q[j] + ATN;
        end
      end
      if (DO_SQ) begin
        if (sv_q[j] >= sum) begin
          svn = sv_q[j] - sum;
          srn = (sr_q[j] >> 1) + SQ_BIT;
        end else begin
          srn = sr_q[j] >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q[j+1] <= 1'b0;
      end else if (adv) begin
        vl_q[j+1] <= vl_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[j+1]   <= r_q[j];
        raw_q[j+1] <= raw_q[j];
        rs_q[j+1]  <= rs_q[j];
        ox_q[j+1]  <= ox_q[j];
        oy_q[j+1]  <= oy_q[j];
        x_q[j+1]   <= xn;
        y_q[j+1]   <= yn;
        t_q[j+1]   <= tn;
        ng_q[j+1]  <= ng_q[j];
        sv_q[j+1]  <= svn;
        sr_q[j+1]  <= srn;
      end
    end
  end

  // Products of the intensity and of the two projections.
  logic signed [33:0] s_fin, c_fin;
  logic [31:0]        s_mag, c_mag;
  logic               p0v_q, p0sn_q, p0cn_q;
  logic [39:0]        p0p_q;
  logic [63:0]        p0sx_q, p0cy_q;
  logic [15:0]        p0r_q;
  logic signed [17:0] p0ox_q, p0oy_q;

  always_comb begin
    s_fin = ng_q[NI] ? -y_q[NI] : y_q[NI];
    c_fin = ng_q[NI] ? -x_q[NI] : x_q[NI];
    s_mag = s_fin[33] ? 32'(-s_fin) : 32'(s_fin);
    c_mag = c_fin[33] ? 32'(-c_fin) : 32'(c_fin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0v_q <= 1'b0;
    end else if (adv) begin
      p0v_q <= vl_q[NI];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0p_q  <= 40'(raw_q[NI]) * 40'(sr_q[NI][23:0]);
      p0sx_q <= 64'(rs_q[NI]) * 64'(s_mag);
      p0cy_q <= 64'(rs_q[NI]) * 64'(c_mag);
      p0sn_q <= s_fin[33];
      p0cn_q <= c_fin[33];
      p0r_q  <= r_q[NI];
      p0ox_q <= ox_q[NI];
      p0oy_q <= oy_q[NI];
    end
  end

  // Rounding, pixel sums and the dividend.
  logic [23:0]        retro1;
  logic [31:0]        div_d;
  logic [48:0]        num;
  logic [64:0]        sx_rnd, cy_rnd;
  logic signed [19:0] sx, cy;
  logic signed [21:0] pxw, pyw;
  logic               p1v_q;
  logic [48:0]        p1n_q;
  logic signed [15:0] p1px_q, p1py_q;
  logic [15:0]        p1r_q;

  always_comb begin
    retro1 = (cfg_i.retro_intensity == '0) ? 24'd1 : cfg_i.retro_intensity;
    div_d  = {retro1, 8'h00};
    num    = 49'({p0p_q, 8'h00}) - 49'(p0p_q) + 49'({retro1, 7'h00});
    sx_rnd = {1'b0, p0sx_q} + (65'd1 << 45);
    cy_rnd = {1'b0, p0cy_q} + (65'd1 << 45);
    sx     = p0sn_q ? -$signed({1'b0, sx_rnd[64:46]}) : $signed({1'b0, sx_rnd[64:46]});
    cy     = p0cn_q ? -$signed({1'b0, cy_rnd[64:46]}) : $signed({1'b0, cy_rnd[64:46]});
    pxw    = $signed({10'd0, cfg_i.center_x}) - 22'(sx) - 22'(p0oy_q);
    pyw    = $signed({10'd0, cfg_i.center_y}) + 22'(cy) - 22'(p0ox_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1v_q <= 1'b0;
    end else if (adv) begin
      p1v_q <= p0v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1n_q  <= num;
      p1px_q <= sat16(pxw);
      p1py_q <= sat16(pyw);
      p1r_q  <= p0r_q;
    end
  end

  // Restoring division, one quotient bit per stage.
  logic               dv_q  [9];
  logic [39:0]        dr_q  [9];
  logic [7:0]         dq_q  [9];
  logic               dc_q  [9];
  logic signed [15:0] dpx_q [9];
  logic signed [15:0] dpy_q [9];
  logic [15:0]        drg_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= p1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dc_q[0]  <= (p1n_q >= 49'({div_d, 8'h00}));
      dr_q[0]  <= p1n_q[39:0];
      dq_q[0]  <= '0;
      dpx_q[0] <= p1px_q;
      dpy_q[0] <= p1py_q;
      drg_q[0] <= p1r_q;
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_div
    localparam int unsigned K = 7 - i;

    logic [39:0] dk, rn;
    logic [7:0]  qn;

    always_comb begin
      dk = 40'(div_d) << K;
      rn = dr_q[i];
      qn = dq_q[i];
      if (dr_q[i] >= dk) begin
        rn    = dr_q[i] - dk;
        qn[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= 1'b0;
      end else if (adv) begin
        dv_q[i+1] <= dv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dr_q[i+1]  <= rn;
        dq_q[i+1]  <= qn;
        dc_q[i+1]  <= dc_q[i];
        dpx_q[i+1] <= dpx_q[i];
        dpy_q[i+1] <= dpy_q[i];
        drg_q[i+1] <= drg_q[i];
      end
    end
  end

  assign out_valid_o      = dv_q[8];
  assign norm_intensity_o = dc_q[8] ? 8'hFF : dq_q[8];
  assign pixel_x_o        = dpx_q[8];
  assign pixel_y_o        = dpy_q[8];
  assign range_out_o      = drg_q[8];

endmodule
`default_nettype wire

// ----- rtl/core/lidar_beam_to_pixel_core.sv -----
// Top level of the lidar beam to pixel core: registers, front end, queue, back end.
//
//   Channel   Signals                                     Direction
//   beam in   in_valid_i, in_stall_o, range/raw/index     sink
//   pixel out out_valid_o, out_stall_i, norm/x/y/range    source
//   config    cfg_we_i, cfg_idx_i, cfg_data_i             write only
//
// One beam is accepted per cycle while results flow out.
// A result is offered once its beam has passed the index, queue, rotation, product,
// rounding and division stages in turn.
// A stall on the output freezes the back end; the queue keeps taking beams until full.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none
`include "lidar_beam_to_pixel_core_defines.svh"
module lidar_beam_to_pixel_core
  import lbp_pkg::*;
#(
  parameter int unsigned SCAN_STEPS   = 2048,
  parameter int unsigned CORDIC_ITERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        range_mm_i,
  input  logic [15:0]        raw_intensity_i,
  input  logic [10:0]        beam_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         norm_intensity_o,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o,
  output logic [15:0]        range_out_o
);

  cfg_t    cfg_q;
  q_stat_t q_stat;
  beam_t   push_data, q_head;
  logic    q_push, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_start     <= 24'd8388608;
      cfg_q.angle_step      <= 24'd11651;
      cfg_q.retro_intensity <= 24'd200000;
      cfg_q.scale           <= 16'd6554;
      cfg_q.center_x        <= 12'd320;
      cfg_q.center_y        <= 12'd320;
      cfg_q.mount_x         <= '0;
      cfg_q.mount_y         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ANGLE_START: cfg_q.angle_start     <= cfg_data_i;
        REG_ANGLE_STEP:  cfg_q.angle_step      <= cfg_data_i;
        REG_RETRO:       cfg_q.retro_intensity <= cfg_data_i;
        REG_SCALE:       cfg_q.scale           <= cfg_data_i[15:0];
        REG_CENTER_X:    cfg_q.center_x        <= cfg_data_i[11:0];
        REG_CENTER_Y:    cfg_q.center_y        <= cfg_data_i[11:0];
        REG_MOUNT_X:     cfg_q.mount_x         <= cfg_data_i[15:0];
        REG_MOUNT_Y:     cfg_q.mount_y         <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  lbp_front #(
    .SCAN_STEPS(SCAN_STEPS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .range_mm_i      (range_mm_i),
    .raw_intensity_i (raw_intensity_i),
    .beam_index_i    (beam_index_i),
    .angle_start_i   (cfg_q.angle_start),
    .angle_step_i    (cfg_q.angle_step),
    .q_full_i        (q_stat.full),
    .push_o          (q_push),
    .push_data_o     (push_data)
  );

  lbp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (push_data),
    .pop_i  (q_pop),
    .data_o (q_head),
    .stat_o (q_stat)
  );

  lbp_back #(
    .CORDIC_ITERS(CORDIC_ITERS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_valid_i     (!q_stat.empty),
    .head_i           (q_head),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .norm_intensity_o (norm_intensity_o),
    .pixel_x_o        (pixel_x_o),
    .pixel_y_o        (pixel_y_o),
    .range_out_o      (range_out_o)
  );

  `LBP_ASSERT_IMP(a_stall_only_when_full, in_stall_o, q_stat.full)
  `LBP_ASSERT_IMP(a_queue_flags, 1'b1, !(q_stat.full && q_stat.empty))
  `LBP_ASSERT_NXT(a_push_fills, q_push && q_stat.empty, !q_stat.empty)
  `LBP_ASSERT_IMP(a_zero_range_dark, out_valid_o && range_out_o == 16'd0, norm_intensity_o == 8'd0)

endmodule
`default_nettype wire
